FILE: rtl/fss_pkg.sv
// shared types, constants and character helpers for the fuzzy subsequence scorer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

    typedef logic [7:0]  t_char;
    typedef logic [4:0]  t_len;
    typedef logic [10:0] t_score;
    typedef logic [1:0]  t_cfg_addr;

    // configuration register indexes
    localparam t_cfg_addr CFG_QUERY_LOW  = 2'd0;
    localparam t_cfg_addr CFG_QUERY_HIGH = 2'd1;
    localparam t_cfg_addr CFG_QUERY_LEN  = 2'd2;

    localparam int    CFG_DATA_W      = 64;
    localparam int    CHARS_PER_WORD  = 8;
    localparam t_char CHAR_NUL        = 8'h00;
    localparam t_char CHAR_UNDERSCORE = 8'h5F;
    localparam t_char CHAR_UP_A       = 8'h41;
    localparam t_char CHAR_UP_Z       = 8'h5A;
    localparam t_char CHAR_LOW_A      = 8'h61;
    localparam t_char CHAR_LOW_Z      = 8'h7A;
    localparam t_char CASE_OFFSET     = 8'h20;

    localparam logic [7:0]  SCORE_HIT      = 8'd1;
    localparam logic [7:0]  SCORE_BOUNDARY = 8'd5;
    localparam t_len        RUN_MAX        = 5'd31;
    localparam t_score      SCORE_MAX      = 11'd2047;

    typedef struct packed {
        t_char qchar;    // query character at the current query index
        t_len  eff_len;  // query length after the cap and the first NUL byte
    } t_query_info;

    typedef struct packed {
        t_score match_score;
        logic   all_matched;
    } t_result;

    function automatic logic is_up(input t_char c);
        is_up = (c >= CHAR_UP_A) && (c <= CHAR_UP_Z);
    endfunction

    function automatic logic is_low(input t_char c);
        is_low = (c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z);
    endfunction

    function automatic t_char fold(input t_char c);
        fold = is_up(c) ? t_char'(c + CASE_OFFSET) : c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fss_query_regs.sv
// query configuration storage and effective query length
// depends on fss_pkg
`timescale 1ns / 1ps
`default_nettype none

module fss_query_regs #(
    parameter int QUERY_LEN = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  fss_pkg::t_cfg_addr      i_cfg_addr,
    input  wire [fss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  fss_pkg::t_len           i_qidx,
    output fss_pkg::t_query_info    o_qinfo
);

    localparam int IDX_W = (QUERY_LEN > 1) ? $clog2(QUERY_LEN) : 1;
    localparam fss_pkg::t_len LEN_MAX = 5'(QUERY_LEN);

    fss_pkg::t_char r_query [QUERY_LEN];
    fss_pkg::t_len  r_qlen;
    fss_pkg::t_len  w_len_cap;
    fss_pkg::t_len  w_eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QUERY_LEN; j++) begin
                r_query[j] <= fss_pkg::CHAR_NUL;
            end
            r_qlen <= '0;
        end else if (i_cfg_we) begin
            for (int j = 0; j < QUERY_LEN; j++) begin
                if (j < fss_pkg::CHARS_PER_WORD) begin
                    if (i_cfg_addr == fss_pkg::CFG_QUERY_LOW) begin
                        r_query[j] <= i_cfg_data[j*8 +: 8];
                    end
                end else begin
                    if (i_cfg_addr == fss_pkg::CFG_QUERY_HIGH) begin
                        r_query[j] <= i_cfg_data[(j-fss_pkg::CHARS_PER_WORD)*8 +: 8];
                    end
                end
            end
            if (i_cfg_addr == fss_pkg::CFG_QUERY_LEN) begin
                r_qlen <= i_cfg_data[4:0];
            end
        end
    end

    // a NUL byte ends the query early; scan from the top so the lowest one wins
    always_comb begin
        w_len_cap = (r_qlen > LEN_MAX) ? LEN_MAX : r_qlen;
        w_eff_len = w_len_cap;
        for (int j = QUERY_LEN - 1; j >= 0; j--) begin
            if ((5'(j) < w_len_cap) && (r_query[j] == fss_pkg::CHAR_NUL)) begin
                w_eff_len = 5'(j);
            end
        end
    end

    assign o_qinfo.eff_len = w_eff_len;
    assign o_qinfo.qchar   = r_query[i_qidx[IDX_W-1:0]];

endmodule

`default_nettype wire

FILE: rtl/fss_scorer.sv
// per-name match state and score update
// depends on fss_pkg
`timescale 1ns / 1ps
`default_nettype none

module fss_scorer #(
    parameter int QUERY_LEN = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  fss_pkg::t_char       i_char,
    input  wire                  i_last,
    input  fss_pkg::t_query_info i_qinfo,
    output fss_pkg::t_len        o_qidx,
    output fss_pkg::t_result     o_result
);

    fss_pkg::t_len   r_qidx,       n_qidx;
    fss_pkg::t_len   r_run,        n_run;
    logic            r_prev_match, n_prev_match;
    fss_pkg::t_char  r_prev_char,  n_prev_char;
    logic            r_at_first,   n_at_first;
    logic            r_name_ended, n_name_ended;
    fss_pkg::t_score r_score,      n_score;

    logic            w_active;
    logic            w_hit;
    logic            w_boundary;
    fss_pkg::t_len   w_run_inc;
    logic [7:0]      w_consec;
    logic [7:0]      w_incr;
    logic [11:0]     w_sum;
    fss_pkg::t_score w_score_sat;
    logic            w_all;

    always_comb begin
        w_active   = i_step && !r_name_ended && (r_qidx < i_qinfo.eff_len);
        w_hit      = fss_pkg::fold(i_char) == fss_pkg::fold(i_qinfo.qchar);
        w_boundary = r_at_first || (r_prev_char == fss_pkg::CHAR_UNDERSCORE) ||
                     (fss_pkg::is_low(r_prev_char) && fss_pkg::is_up(i_char));
        w_run_inc  = (r_run < fss_pkg::RUN_MAX) ? r_run + 5'd1 : r_run;
        w_consec   = r_prev_match ? {w_run_inc, 3'b000} : 8'd0;
        w_incr     = fss_pkg::SCORE_HIT + w_consec +
                     (w_boundary ? fss_pkg::SCORE_BOUNDARY : 8'd0);
        w_sum      = {1'b0, r_score} + 12'(w_incr);
        w_score_sat = w_sum[11] ? fss_pkg::SCORE_MAX : w_sum[10:0];
    end

    always_comb begin
        n_qidx       = r_qidx;
        n_run        = r_run;
        n_prev_match = r_prev_match;
        n_prev_char  = r_prev_char;
        n_at_first   = r_at_first;
        n_name_ended = r_name_ended;
        n_score      = r_score;
        if (w_active) begin
            if (i_char == fss_pkg::CHAR_NUL) begin
                n_name_ended = 1'b1;
            end else begin
                if (w_hit) begin
                    n_score      = w_score_sat;
                    n_run        = r_prev_match ? w_run_inc : 5'd0;
                    n_qidx       = r_qidx + 5'd1;
                    n_prev_match = 1'b1;
                end else begin
                    n_prev_match = 1'b0;
                end
                n_prev_char = i_char;
                n_at_first  = 1'b0;
            end
        end

        // result sees the state after this character
        w_all                 = n_qidx >= i_qinfo.eff_len;
        o_result.all_matched  = w_all;
        o_result.match_score  = (w_all && (i_qinfo.eff_len != 5'd0)) ? n_score : '0;

        if (i_step && i_last) begin
            n_qidx       = '0;
            n_run        = '0;
            n_prev_match = 1'b1;
            n_prev_char  = fss_pkg::CHAR_NUL;
            n_at_first   = 1'b1;
            n_name_ended = 1'b0;
            n_score      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qidx       <= '0;
            r_run        <= '0;
            r_prev_match <= 1'b1;
            r_prev_char  <= fss_pkg::CHAR_NUL;
            r_at_first   <= 1'b1;
            r_name_ended <= 1'b0;
            r_score      <= '0;
        end else begin
            r_qidx       <= n_qidx;
            r_run        <= n_run;
            r_prev_match <= n_prev_match;
            r_prev_char  <= n_prev_char;
            r_at_first   <= n_at_first;
            r_name_ended <= n_name_ended;
            r_score      <= n_score;
        end
    end

    assign o_qidx = r_qidx;

    // score only grows on a match, and every match advances the query index
    a_score_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qidx == 5'd0) |-> (r_score == '0))
        else $error("score nonzero with no matched query character");

    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= r_qidx)
        else $error("run length exceeds matched count");

    a_first_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_first |-> ((r_qidx == 5'd0) && r_prev_match))
        else $error("match recorded before any character was consumed");

    a_qidx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qidx <= 5'(QUERY_LEN))
        else $error("query index past query storage");

endmodule

`default_nettype wire

FILE: rtl/fuzzy_subsequence_score_top.sv
// top level: input register, scorer, result register and handshakes
// depends on fss_pkg, fss_query_regs, fss_scorer
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one name character per
//   transfer with i_last_char marking the final character of a name. output
//   channel (o_out_valid / i_out_ready) carries one result per name:
//   o_match_score and o_all_matched. the query is loaded through the write
//   port (i_cfg_we, i_cfg_addr, i_cfg_data) while no name is in flight:
//   index 0 query chars 0..7, index 1 chars 8..15, index 2 query length.
// timing:
//   one character per cycle sustained while no name end waits for the
//   result slot. characters are scored from the input register; once the
//   slot is free the result of a name is latched into the result register
//   and offered. the combinational compare and add of the scorer sets the rate.
// reset and stall:
//   synchronous active-low reset clears the query, the per-name state and
//   both handshake registers. while the output holds an untaken result,
//   characters that do not end a name keep flowing; a name end waits in the
//   input register until the result slot frees up.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_subsequence_score_top #(
    parameter int QUERY_LEN = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [1:0]                     i_cfg_addr,
    input  wire [fss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [7:0]                     i_name_char,
    input  wire                           i_last_char,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [10:0]                   o_match_score,
    output logic                          o_all_matched
);

    logic                 r_in_valid;
    fss_pkg::t_char       r_in_char;
    logic                 r_in_last;
    logic                 r_out_valid;
    fss_pkg::t_result     r_out;

    logic                 w_advance;
    logic                 w_in_xfer;
    fss_pkg::t_query_info w_qinfo;
    fss_pkg::t_len        w_qidx;
    fss_pkg::t_result     w_result;

    // a name end needs a free result slot, other characters always move on
    assign w_advance  = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_char <= i_name_char;
            r_in_last <= i_last_char;
        end
    end

    fss_query_regs #(
        .QUERY_LEN (QUERY_LEN)
    ) u_query_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_qidx     (w_qidx),
        .o_qinfo    (w_qinfo)
    );

    fss_scorer #(
        .QUERY_LEN (QUERY_LEN)
    ) u_scorer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .i_qinfo  (w_qinfo),
        .o_qidx   (w_qidx),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_score = r_out.match_score;
    assign o_all_matched = r_out.all_matched;

    a_score_implies_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_match_score != 11'd0)) |-> o_all_matched)
        else $error("nonzero score without a full match");

    a_name_end_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !i_out_ready) |=>
            (r_in_valid && r_in_last))
        else $error("name end dropped while result slot was busy");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: test/fuzzy_subsequence_score_top_tb.sv
`timescale 1ns / 1ps
// testbench for fuzzy_subsequence_score_top: streams symbol names, scores each one
// with its own model and checks every result transfer field by field
// depends on fss_pkg and the rtl of fuzzy_subsequence_score_top

module fuzzy_subsequence_score_top_tb;

    localparam int     CLK_PERIOD    = 20;
    localparam int     RESET_CYCLES  = 6;
    localparam int     MAX_GAP       = 12;
    localparam int     SETTLE_CYCLES = 6;
    localparam int     RANDOM_ITEMS  = 600;
    localparam int     PHASE_ITEMS   = 90;
    localparam int     REPORT_LIMIT  = 10;
    localparam int     CONSEC_WEIGHT = 8;
    localparam int     QUERY_SLOTS   = 16;
    localparam longint RUN_LIMIT_NS  = 10_000_000;
    localparam string  SYMBOLS       = "aAbBcC_xXyYzZ09";

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_we      = 1'b0;
    fss_pkg::t_cfg_addr             cfg_addr    = fss_pkg::CFG_QUERY_LOW;
    logic [fss_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    fss_pkg::t_char                 name_char   = fss_pkg::CHAR_NUL;
    logic                           last_char   = 1'b0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic [10:0]                    match_score;
    logic                           all_matched;

    // shadow of the query registers
    logic [63:0]   query_low  = '0;
    logic [63:0]   query_high = '0;
    fss_pkg::t_len query_len  = '0;

    // per-name scoring state
    int             query_pos;
    int             run_len;
    logic           prev_hit;
    fss_pkg::t_char prev_char;
    logic           first_pos;
    logic           name_done;
    int             acc_score;

    fss_pkg::t_result pending_scores[$];
    int      mismatches    = 0;
    int      sent_items    = 0;
    int      results_taken = 0;
    int      sink_seen     = 0;
    int      sink_wait     = 0;
    logic    send_gaps_on  = 1'b1;
    logic    sink_gaps_on  = 1'b1;

    fuzzy_subsequence_score_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_name_char   (name_char),
        .i_last_char   (last_char),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_match_score (match_score),
        .o_all_matched (all_matched)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("[fuzzy_subsequence_score_top] ERROR");
        $finish;
    end

    function automatic fss_pkg::t_char query_byte(input int i);
        return (i < fss_pkg::CHARS_PER_WORD) ? query_low[8*i +: 8]
                                             : query_high[8*(i-8) +: 8];
    endfunction

    // length in use: capped at the slot count and cut at the first zero byte
    function automatic int active_length();
        int n;
        n = (int'(query_len) > QUERY_SLOTS) ? QUERY_SLOTS : int'(query_len);
        for (int i = 0; i < n; i++) begin
            if (query_byte(i) == fss_pkg::CHAR_NUL) return i;
        end
        return n;
    endfunction

    function automatic logic is_lower_letter(input fss_pkg::t_char c);
        return (c >= fss_pkg::CHAR_LOW_A) && (c <= fss_pkg::CHAR_LOW_Z);
    endfunction

    function automatic logic is_upper_letter(input fss_pkg::t_char c);
        return (c >= fss_pkg::CHAR_UP_A) && (c <= fss_pkg::CHAR_UP_Z);
    endfunction

    function automatic fss_pkg::t_char case_folded(input fss_pkg::t_char c);
        return is_upper_letter(c) ? fss_pkg::t_char'(c + fss_pkg::CASE_OFFSET) : c;
    endfunction

    function automatic fss_pkg::t_char random_symbol();
        if ($urandom_range(0, 19) == 0) return fss_pkg::t_char'($urandom_range(1, 255));
        return SYMBOLS[$urandom_range(0, SYMBOLS.len() - 1)];
    endfunction

    task automatic add_points(input int pts);
        acc_score = (acc_score + pts > int'(fss_pkg::SCORE_MAX)) ?
                    int'(fss_pkg::SCORE_MAX) : acc_score + pts;
    endtask

    task automatic clear_name_state();
        query_pos = 0;
        run_len   = 0;
        prev_hit  = 1'b1;   // position minus one counts as matched
        prev_char = fss_pkg::CHAR_NUL;
        first_pos = 1'b1;
        name_done = 1'b0;
        acc_score = 0;
    endtask

    // advance the scoring state by one accepted character
    task automatic score_char(input fss_pkg::t_char c, input logic last);
        int               len;
        logic             full;
        fss_pkg::t_result res;
        len = active_length();
        if (!name_done && query_pos < len) begin
            if (c == fss_pkg::CHAR_NUL) begin
                name_done = 1'b1;
            end else begin
                if (case_folded(c) == case_folded(query_byte(query_pos))) begin
                    add_points(int'(fss_pkg::SCORE_HIT));
                    if (prev_hit) begin
                        if (run_len < int'(fss_pkg::RUN_MAX)) run_len++;
                        add_points(CONSEC_WEIGHT * run_len);
                    end else begin
                        run_len = 0;
                    end
                    if (first_pos || prev_char == fss_pkg::CHAR_UNDERSCORE ||
                        (is_lower_letter(prev_char) && is_upper_letter(c)))
                        add_points(int'(fss_pkg::SCORE_BOUNDARY));
                    query_pos++;
                    prev_hit = 1'b1;
                end else begin
                    prev_hit = 1'b0;
                end
                prev_char = c;
                first_pos = 1'b0;
            end
        end
        if (last) begin
            full            = (query_pos >= len);
            res.match_score = (full && len > 0) ? fss_pkg::t_score'(acc_score) : '0;
            res.all_matched = full;
            pending_scores.push_back(res);
            clear_name_state();
        end
    endtask

    task automatic report_mismatch(input string what, input int expected, input int actual);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, expected,
                     actual);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_char(input fss_pkg::t_char c, input logic last);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        name_char = c;
        last_char = last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        score_char(c, last);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // hold off the input until every score is back and the pipeline is empty
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_scores.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input fss_pkg::t_cfg_addr addr,
                             input logic [fss_pkg::CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_addr = addr;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_query(input logic [63:0] lo, input logic [63:0] hi,
                              input fss_pkg::t_len len);
        wait_idle();
        write_reg(fss_pkg::CFG_QUERY_LEN, fss_pkg::CFG_DATA_W'(len));
        write_reg(fss_pkg::CFG_QUERY_HIGH, hi);
        write_reg(fss_pkg::CFG_QUERY_LOW, lo);
        query_low  = lo;
        query_high = hi;
        query_len  = len;
    endtask

    task automatic load_query_text(input string s, input fss_pkg::t_len len);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = '0;
        hi = '0;
        for (int i = 0; i < s.len(); i++) begin
            if (i < fss_pkg::CHARS_PER_WORD) lo[8*i +: 8] = s[i];
            else hi[8*(i-8) +: 8] = s[i];
        end
        load_query(lo, hi, len);
    endtask

    task automatic test_directed_matching();
        send_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        load_query_text("ab", 5'd2);
        send_text("ab");      // run starting at position zero
        send_text("xaB");     // case folded, camel-case boundary
        send_text("_ab");     // boundary after underscore
        send_text("a");       // query only partly matched
        // nul ends the name, the rest is ignored
        send_char("a", 1'b0);
        send_char(fss_pkg::CHAR_NUL, 1'b0);
        send_char("b", 1'b1);
        // characters after the query is used up are ignored
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_empty_query();
        load_query_text("ab", 5'd0);
        send_text("a");
        // zero first byte makes the query empty despite a nonzero length
        load_query(64'h0000_0000_0000_7900, 64'h0, 5'd2);
        send_char(fss_pkg::CHAR_NUL, 1'b1);
    endtask

    task automatic test_long_query();
        send_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        load_query({64{1'b1}}, 64'h4141_4141_4141_4141, 5'd16);
        for (int i = 0; i < 8; i++) send_char(8'hFF, 1'b0);
        for (int i = 0; i < 8; i++) send_char("a", i == 7);
    endtask

    task automatic test_random_names();
        int             random_items;
        int             phase_start;
        int             len;
        int             style;
        int             keep;
        int             pick;
        fss_pkg::t_char c;
        logic [63:0]    lo;
        logic [63:0]    hi;
        fss_pkg::t_len  qlen;
        fss_pkg::t_char name[$];
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 7);
            qlen = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd16 :
                   fss_pkg::t_len'($urandom_range(1, 16));
            if ($urandom_range(0, 5) == 0) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end else begin
                for (int i = 0; i < QUERY_SLOTS; i++) begin
                    c = ($urandom_range(0, 39) == 0) ? fss_pkg::CHAR_NUL : random_symbol();
                    if (i < fss_pkg::CHARS_PER_WORD) lo[8*i +: 8] = c;
                    else hi[8*(i-8) +: 8] = c;
                end
            end
            load_query(lo, hi, qlen);
            send_gaps_on = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            phase_start  = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                name.delete();
                len   = active_length();
                style = $urandom_range(0, 9);
                if (style < 7 && len > 0) begin
                    // the query spelled out with noise and case changes
                    for (int i = 0; i < len; i++) begin
                        repeat ($urandom_range(0, 2)) name.push_back(random_symbol());
                        c = query_byte(i);
                        if ($urandom_range(0, 1) == 1) begin
                            if (is_upper_letter(c)) c = c + fss_pkg::CASE_OFFSET;
                            else if (is_lower_letter(c)) c = c - fss_pkg::CASE_OFFSET;
                        end
                        name.push_back(c);
                    end
                    if (style == 6) begin
                        keep = $urandom_range(1, name.size());
                        while (name.size() > keep) void'(name.pop_back());
                    end
                    repeat ($urandom_range(0, 3)) name.push_back(random_symbol());
                    if ($urandom_range(0, 9) == 0)
                        name.insert($urandom_range(0, name.size() - 1), fss_pkg::CHAR_NUL);
                end else begin
                    repeat ($urandom_range(1, 12))
                        name.push_back(fss_pkg::t_char'($urandom_range(0, 255)));
                end
                foreach (name[i]) send_char(name[i], i == name.size() - 1);
                if ($urandom_range(0, 15) == 0) wait_idle();
            end
            random_items += sent_items - phase_start;
        end
    endtask

    always @(posedge clk) begin : check_results
        fss_pkg::t_result want;
        if (rst_n && out_valid && out_ready) begin
            results_taken++;
            if (pending_scores.size() == 0) begin
                report_mismatch("unexpected result score", 0, match_score);
            end else begin
                want = pending_scores.pop_front();
                if (match_score !== want.match_score)
                    report_mismatch("match_score", want.match_score, match_score);
                if (all_matched !== want.all_matched)
                    report_mismatch("all_matched", want.all_matched, all_matched);
            end
        end
    end

    // receiver stalls drawn once per result transfer
    always @(negedge clk) begin
        if (results_taken != sink_seen) begin
            sink_seen = results_taken;
            sink_wait = sink_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (sink_wait > 0) begin
            out_ready = 1'b0;
            sink_wait--;
        end else begin
            out_ready = 1'b1;
        end
    end

    initial begin
        clear_name_state();
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        test_directed_matching();
        test_empty_query();
        test_long_query();
        test_random_names();
        wait_idle();
        if (pending_scores.size() != 0)
            report_mismatch("results left pending", 0, pending_scores.size());
        if (mismatches == 0) begin
            $display("[fuzzy_subsequence_score_top] OK");
        end else begin
            $display("[fuzzy_subsequence_score_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/fss_pkg.sv
rtl/fss_query_regs.sv
rtl/fss_scorer.sv
rtl/fuzzy_subsequence_score_top.sv
test/fuzzy_subsequence_score_top_tb.sv
